// ===== rtl/sfsd_pkg.sv =====
// Package for the speed filter with settle detect: payload and register types,
// microcode control word, register map and the shared saturation helper.
// No dependencies.
package sfsd_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int STEP_W = 4;
  localparam int PROD_W = 58;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 33;

  localparam logic [2:0] REG_GEARING      = 3'd0;
  localparam logic [2:0] REG_RECIP        = 3'd1;
  localparam logic [2:0] REG_TARGET       = 3'd2;
  localparam logic [2:0] REG_THR_ERR      = 3'd3;
  localparam logic [2:0] REG_THR_DER      = 3'd4;
  localparam logic [2:0] REG_CHECK_CYCLE  = 3'd5;
  localparam logic [2:0] REG_DELAY_READY  = 3'd6;
  localparam logic [2:0] REG_DELAY_ACTIVE = 3'd7;

  localparam logic [15:0] GEARING_RST      = 16'd256;
  localparam logic [23:0] RECIP_RST        = 24'd655360;
  localparam logic [7:0]  CHECK_CYCLE_RST  = 8'd10;
  localparam logic [15:0] DELAY_READY_RST  = 16'd20;
  localparam logic [15:0] DELAY_ACTIVE_RST = 16'd20;

  localparam logic signed [PROD_W-1:0] S24_MAX = PROD_W'(8388607);
  localparam logic signed [PROD_W-1:0] S24_MIN = -PROD_W'(8388608);

  typedef struct packed {
    logic signed [23:0] raw_speed;
    logic [19:0]        elapsed;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] filtered_speed;
    logic signed [23:0] filtered_slope;
    logic signed [23:0] speed_error;
    logic               is_ready;
    logic               became_ready;
    logic               became_active;
    logic [15:0]        frame_delay;
  } result_t;

  typedef struct packed {
    logic [15:0]        gearing;
    logic [23:0]        smoothing_recip;
    logic signed [23:0] target_speed;
    logic [22:0]        threshold_error;
    logic [22:0]        threshold_derivative;
    logic [7:0]         check_cycle;
    logic [15:0]        delay_ready;
    logic [15:0]        delay_active;
  } cfg_t;

  typedef enum logic [1:0] {BR_NEXT, BR_WAIT_IN, BR_WAIT_OUT, BR_JUMP0} br_t;
  typedef enum logic [2:0] {A_NONE, A_RAW, A_ELAPSED, A_DIFF, A_DSLOPE} asel_t;
  typedef enum logic [1:0] {B_GEAR, B_RECIP, B_GAIN} bsel_t;
  typedef enum logic [1:0] {SH8, SH12, SH16, SH24} sh_t;
  typedef enum logic [2:0] {
    WB_NONE, WB_SCALED, WB_GAIN, WB_DERIV, WB_SPEED, WB_SLOPE
  } wb_t;

  typedef struct packed {
    br_t   br;
    asel_t a_sel;
    bsel_t b_sel;
    sh_t   sh;
    wb_t   wb;
    logic  ld_in;
    logic  ld_diff;
    logic  ld_dslope;
    logic  ld_err;
    logic  ld_out;
  } ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < S24_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sfsd_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on sfsd_pkg for the register map, reset values and cfg_t.
module sfsd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfsd_pkg::ADDR_W-1:0] paddr,
  input  logic [sfsd_pkg::DATA_W-1:0] pwdata,
  output logic [sfsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sfsd_pkg::cfg_t             cfg,
  output logic                       target_wr
);

  logic [2:0] idx;
  logic       wr;

  assign pready    = 1'b1;
  assign idx       = paddr[4:2];
  assign wr        = psel && penable && pwrite && pready;
  assign target_wr = wr && (idx == sfsd_pkg::REG_TARGET);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gearing              <= sfsd_pkg::GEARING_RST;
      cfg.smoothing_recip      <= sfsd_pkg::RECIP_RST;
      cfg.target_speed         <= '0;
      cfg.threshold_error      <= '0;
      cfg.threshold_derivative <= '0;
      cfg.check_cycle          <= sfsd_pkg::CHECK_CYCLE_RST;
      cfg.delay_ready          <= sfsd_pkg::DELAY_READY_RST;
      cfg.delay_active         <= sfsd_pkg::DELAY_ACTIVE_RST;
    end else if (wr) begin
      unique case (idx)
        sfsd_pkg::REG_GEARING:      cfg.gearing              <= pwdata[15:0];
        sfsd_pkg::REG_RECIP:        cfg.smoothing_recip      <= pwdata[23:0];
        sfsd_pkg::REG_TARGET:       cfg.target_speed         <= pwdata[23:0];
        sfsd_pkg::REG_THR_ERR:      cfg.threshold_error      <= pwdata[22:0];
        sfsd_pkg::REG_THR_DER:      cfg.threshold_derivative <= pwdata[22:0];
        sfsd_pkg::REG_CHECK_CYCLE:  cfg.check_cycle          <= pwdata[7:0];
        sfsd_pkg::REG_DELAY_READY:  cfg.delay_ready          <= pwdata[15:0];
        sfsd_pkg::REG_DELAY_ACTIVE: cfg.delay_active         <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfsd_pkg::REG_GEARING:      prdata = {16'd0, cfg.gearing};
      sfsd_pkg::REG_RECIP:        prdata = {8'd0, cfg.smoothing_recip};
      sfsd_pkg::REG_TARGET:       prdata = {{8{cfg.target_speed[23]}}, cfg.target_speed};
      sfsd_pkg::REG_THR_ERR:      prdata = {9'd0, cfg.threshold_error};
      sfsd_pkg::REG_THR_DER:      prdata = {9'd0, cfg.threshold_derivative};
      sfsd_pkg::REG_CHECK_CYCLE:  prdata = {24'd0, cfg.check_cycle};
      sfsd_pkg::REG_DELAY_READY:  prdata = {16'd0, cfg.delay_ready};
      sfsd_pkg::REG_DELAY_ACTIVE: prdata = {16'd0, cfg.delay_active};
    endcase
  end

endmodule

// ===== rtl/sfsd_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and wait/jump logic.
// Depends on sfsd_pkg for ctrl_t and its field codes.
module sfsd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  input  logic            out_free,
  output sfsd_pkg::ctrl_t cw,
  output logic            fire,
  output logic            sample_stall
);

  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_ACCEPT = 4'd0;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_SCALE  = 4'd1;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_GAIN   = 4'd2;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_DMUL   = 4'd3;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_DERIV  = 4'd4;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_SPEED  = 4'd5;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_SMUL   = 4'd6;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_SLOPE  = 4'd7;
  localparam logic [sfsd_pkg::STEP_W-1:0] STEP_OUT    = 4'd8;

  logic [sfsd_pkg::STEP_W-1:0] step;
  logic [sfsd_pkg::STEP_W-1:0] step_next;

  function automatic sfsd_pkg::ctrl_t ucode(input logic [sfsd_pkg::STEP_W-1:0] s);
    sfsd_pkg::ctrl_t c;
    c = '0;
    unique case (s)
      STEP_ACCEPT: begin
        c.br = sfsd_pkg::BR_WAIT_IN; c.a_sel = sfsd_pkg::A_RAW;
        c.b_sel = sfsd_pkg::B_GEAR; c.sh = sfsd_pkg::SH8; c.ld_in = 1'b1;
      end
      STEP_SCALE: begin
        c.wb = sfsd_pkg::WB_SCALED; c.a_sel = sfsd_pkg::A_ELAPSED;
        c.b_sel = sfsd_pkg::B_RECIP; c.sh = sfsd_pkg::SH12;
      end
      STEP_GAIN: begin
        c.wb = sfsd_pkg::WB_GAIN; c.ld_diff = 1'b1;
      end
      STEP_DMUL: begin
        c.a_sel = sfsd_pkg::A_DIFF; c.b_sel = sfsd_pkg::B_RECIP; c.sh = sfsd_pkg::SH16;
      end
      STEP_DERIV: begin
        c.wb = sfsd_pkg::WB_DERIV; c.a_sel = sfsd_pkg::A_DIFF;
        c.b_sel = sfsd_pkg::B_GAIN; c.sh = sfsd_pkg::SH24;
      end
      STEP_SPEED: begin
        c.wb = sfsd_pkg::WB_SPEED; c.ld_dslope = 1'b1;
      end
      STEP_SMUL: begin
        c.a_sel = sfsd_pkg::A_DSLOPE; c.b_sel = sfsd_pkg::B_GAIN;
        c.sh = sfsd_pkg::SH24; c.ld_err = 1'b1;
      end
      STEP_SLOPE: begin
        c.wb = sfsd_pkg::WB_SLOPE;
      end
      STEP_OUT: begin
        c.br = sfsd_pkg::BR_WAIT_OUT; c.ld_out = 1'b1;
      end
      default: begin
        c.br = sfsd_pkg::BR_JUMP0;
      end
    endcase
    return c;
  endfunction

  assign cw           = ucode(step);
  assign sample_stall = (cw.br != sfsd_pkg::BR_WAIT_IN);

  always_comb begin
    case (cw.br)
      sfsd_pkg::BR_WAIT_IN:  fire = sample_valid;
      sfsd_pkg::BR_WAIT_OUT: fire = out_free;
      default:               fire = 1'b1;
    endcase
  end

  always_comb begin
    step_next = step;
    if (fire) begin
      if (cw.br == sfsd_pkg::BR_WAIT_OUT || cw.br == sfsd_pkg::BR_JUMP0) begin
        step_next = STEP_ACCEPT;
      end else begin
        step_next = step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/sfsd_datapath.sv =====
// Datapath: shared multiplier with rounding, writeback/saturation, filter state,
// settle check and result register. Depends on sfsd_pkg for types and sat24.
module sfsd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sfsd_pkg::ctrl_t   cw,
  input  logic              fire,
  input  sfsd_pkg::cfg_t    cfg,
  input  logic              target_wr,
  input  sfsd_pkg::sample_t sample,
  output logic              out_free,
  output logic              result_valid,
  input  logic              result_stall,
  output sfsd_pkg::result_t result
);

  localparam int PW = sfsd_pkg::PROD_W;

  logic [19:0]                          elapsed_q;
  logic signed [sfsd_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [sfsd_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [PW-1:0]                 prod;
  logic signed [PW-1:0]                 rnd_c;
  logic signed [PW-1:0]                 p;
  sfsd_pkg::sh_t                        p_sh;
  logic signed [PW-1:0]                 shifted;
  logic signed [PW-1:0]                 base;
  logic signed [PW-1:0]                 wb_sum;
  logic signed [23:0]                   wb_sat;
  logic signed [23:0]                   scaled;
  logic [31:0]                          gain;
  logic signed [24:0]                   diff;
  logic signed [23:0]                   deriv;
  logic signed [24:0]                   dslope;
  logic signed [23:0]                   speed;
  logic signed [23:0]                   slope;
  logic signed [23:0]                   err;
  logic                                 ready;
  logic [7:0]                           cnt;
  logic [7:0]                           cnt_inc;
  logic                                 check;
  logic [23:0]                          abs_err;
  logic [23:0]                          abs_slope;
  logic                                 settled;
  logic                                 rose;
  logic                                 fell;
  logic                                 ready_next;
  logic                                 act;

  assign act      = fire;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    case (cw.a_sel)
      sfsd_pkg::A_RAW:     mul_a = {sample.raw_speed[23], sample.raw_speed};
      sfsd_pkg::A_ELAPSED: mul_a = {5'd0, elapsed_q};
      sfsd_pkg::A_DIFF:    mul_a = diff;
      sfsd_pkg::A_DSLOPE:  mul_a = dslope;
      default:             mul_a = '0;
    endcase
    case (cw.b_sel)
      sfsd_pkg::B_GEAR:  mul_b = {17'd0, cfg.gearing};
      sfsd_pkg::B_RECIP: mul_b = {9'd0, cfg.smoothing_recip};
      sfsd_pkg::B_GAIN:  mul_b = {1'b0, gain};
      default:           mul_b = '0;
    endcase
    case (cw.sh)
      sfsd_pkg::SH8:  rnd_c = PW'(1) <<< 7;
      sfsd_pkg::SH12: rnd_c = PW'(1) <<< 11;
      sfsd_pkg::SH16: rnd_c = PW'(1) <<< 15;
      default:        rnd_c = PW'(1) <<< 23;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (p_sh)
      sfsd_pkg::SH8:  shifted = p >>> 8;
      sfsd_pkg::SH12: shifted = p >>> 12;
      sfsd_pkg::SH16: shifted = p >>> 16;
      default:        shifted = p >>> 24;
    endcase
    case (cw.wb)
      sfsd_pkg::WB_SPEED: base = PW'(speed);
      sfsd_pkg::WB_SLOPE: base = PW'(slope);
      default:            base = '0;
    endcase
  end

  assign wb_sum = shifted + base;
  assign wb_sat = sfsd_pkg::sat24(wb_sum);

  assign cnt_inc    = cnt + 8'd1;
  assign check      = (cnt_inc >= cfg.check_cycle);
  assign abs_err    = err[23] ? (~err + 24'd1) : err;
  assign abs_slope  = slope[23] ? (~slope + 24'd1) : slope;
  assign settled    = (abs_err <= {1'b0, cfg.threshold_error}) &&
                      (abs_slope <= {1'b0, cfg.threshold_derivative});
  assign rose       = check && settled && !ready;
  assign fell       = check && !settled && ready;
  assign ready_next = rose ? 1'b1 : (fell ? 1'b0 : ready);

  always_ff @(posedge clk) begin
    if (act && cw.ld_in) begin
      elapsed_q <= sample.elapsed;
    end
    if (act && cw.a_sel != sfsd_pkg::A_NONE) begin
      p    <= prod + rnd_c;
      p_sh <= cw.sh;
    end
    if (act && cw.wb == sfsd_pkg::WB_SCALED) begin
      scaled <= wb_sat;
    end
    if (act && cw.wb == sfsd_pkg::WB_GAIN) begin
      gain <= shifted[31:0];
    end
    if (act && cw.wb == sfsd_pkg::WB_DERIV) begin
      deriv <= wb_sat;
    end
    if (act && cw.ld_diff) begin
      diff <= {scaled[23], scaled} - {speed[23], speed};
    end
    if (act && cw.ld_dslope) begin
      dslope <= {deriv[23], deriv} - {slope[23], slope};
    end
    if (act && cw.ld_err) begin
      err <= sfsd_pkg::sat24(PW'(speed) - PW'(cfg.target_speed));
    end
    if (act && cw.ld_out) begin
      result.filtered_speed <= speed;
      result.filtered_slope <= slope;
      result.speed_error    <= err;
      result.is_ready       <= ready_next;
      result.became_ready   <= rose;
      result.became_active  <= fell;
      result.frame_delay    <= ready_next ? cfg.delay_ready : cfg.delay_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed        <= '0;
      slope        <= '0;
      ready        <= 1'b1;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (act && cw.wb == sfsd_pkg::WB_SPEED) begin
        speed <= wb_sat;
      end
      if (act && cw.wb == sfsd_pkg::WB_SLOPE) begin
        slope <= wb_sat;
      end
      if (target_wr) begin
        ready <= 1'b0;
      end else if (act && cw.ld_out) begin
        ready <= ready_next;
      end
      if (act && cw.ld_out) begin
        cnt          <= check ? 8'd0 : cnt_inc;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/speed_filter_settle_detect.sv =====
// Channel   | Dir | Handshake                 | Payload
// sample    | in  | sample_valid/sample_stall | sfsd_pkg::sample_t
// result    | out | result_valid/result_stall | sfsd_pkg::result_t
// config    | in  | psel/penable/pwrite/pready| paddr, pwdata, prdata
// Each sample is worked by a 9-step microcode program that drives one shared
// 25x33 multiplier; the result is loaded in the last step, and sample_stall drops
// in the cycle after the result is loaded, so only one sample is in work at a time.
// Reset is synchronous: estimates cleared, ready flag set, registers to defaults.
// A stalled result holds in the output register; the program waits in its
// last step until that register frees, then accepts the next sample.
// Top level: instantiates sfsd_regs, sfsd_seq and sfsd_datapath; uses sfsd_pkg.
module speed_filter_settle_detect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  sfsd_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_stall,
  output sfsd_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfsd_pkg::ADDR_W-1:0] paddr,
  input  logic [sfsd_pkg::DATA_W-1:0] pwdata,
  output logic [sfsd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  sfsd_pkg::cfg_t  cfg;
  sfsd_pkg::ctrl_t cw;
  logic            target_wr;
  logic            fire;
  logic            out_free;

  sfsd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .target_wr (target_wr)
  );

  sfsd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .out_free     (out_free),
    .cw           (cw),
    .fire         (fire),
    .sample_stall (sample_stall)
  );

  sfsd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cw           (cw),
    .fire         (fire),
    .cfg          (cfg),
    .target_wr    (target_wr),
    .sample       (sample),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/sfsd_checker.sv =====
// Port-level checker for the speed filter with settle detect, bound to the top.
// Depends on sfsd_pkg for the result type.
module sfsd_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input sfsd_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous one in work");

  a_edges: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.became_ready && result.became_active))
    else $error("rise and fall in one result");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.became_ready || result.became_active) |->
      result.is_ready == result.became_ready)
    else $error("ready flag disagrees with reported edge");

endmodule

bind speed_filter_settle_detect sfsd_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== test/tb_speed_filter_settle_detect.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for speed_filter_settle_detect: a directed table, then random
// settle runs and noise under changing register settings and idle patterns.
// Depends on sfsd_pkg and the speed_filter_settle_detect RTL.
module tb_speed_filter_settle_detect;
  import sfsd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 68;

  typedef struct {
    bit          wr_en;
    logic [2:0]  wr_reg;
    logic [31:0] wr_val;
    sample_t     smp;
    bit          known;
    result_t     want;
  } script_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  sample_t           sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t               flt_cfg;
  logic signed [23:0] est_speed;
  logic signed [23:0] est_slope;
  bit                 settled_flag;
  logic [7:0]         samples_seen;

  result_t     expected_results[$];
  script_row_t script[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  speed_filter_settle_detect dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint rshift_round(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic result_t predict_filter(sample_t s);
    longint  scaled, gain, diff, deriv, err, err_mag, slope_mag;
    bit      settled, rose, fell;
    result_t r;
    scaled = clamp24(rshift_round(longint'($signed(s.raw_speed)) *
                                  longint'(flt_cfg.gearing), 8));
    gain = rshift_round(longint'(s.elapsed) * longint'(flt_cfg.smoothing_recip), 12);
    diff = scaled - longint'(est_speed);
    deriv = clamp24(rshift_round(diff * longint'(flt_cfg.smoothing_recip), 16));
    est_speed = clamp24(longint'(est_speed) + rshift_round(diff * gain, 24));
    est_slope = clamp24(longint'(est_slope) +
                        rshift_round((deriv - longint'(est_slope)) * gain, 24));
    err = clamp24(longint'(est_speed) - longint'($signed(flt_cfg.target_speed)));
    rose = 1'b0;
    fell = 1'b0;
    samples_seen = samples_seen + 8'd1;
    if (samples_seen >= flt_cfg.check_cycle || flt_cfg.check_cycle == 8'd0) begin
      err_mag = err < 0 ? -err : err;
      slope_mag = est_slope < 0 ? -longint'(est_slope) : longint'(est_slope);
      settled = err_mag <= longint'(flt_cfg.threshold_error) &&
                slope_mag <= longint'(flt_cfg.threshold_derivative);
      samples_seen = 8'd0;
      if (settled && !settled_flag) begin
        settled_flag = 1'b1;
        rose = 1'b1;
      end else if (!settled && settled_flag) begin
        settled_flag = 1'b0;
        fell = 1'b1;
      end
    end
    r.filtered_speed = est_speed;
    r.filtered_slope = est_slope;
    r.speed_error = err[23:0];
    r.is_ready = settled_flag;
    r.became_ready = rose;
    r.became_active = fell;
    r.frame_delay = settled_flag ? flt_cfg.delay_ready : flt_cfg.delay_active;
    return r;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_GEARING:      flt_cfg.gearing = v[15:0];
      REG_RECIP:        flt_cfg.smoothing_recip = v[23:0];
      REG_TARGET: begin
        flt_cfg.target_speed = v[23:0];
        settled_flag = 1'b0;
      end
      REG_THR_ERR:      flt_cfg.threshold_error = v[22:0];
      REG_THR_DER:      flt_cfg.threshold_derivative = v[22:0];
      REG_CHECK_CYCLE:  flt_cfg.check_cycle = v[7:0];
      REG_DELAY_READY:  flt_cfg.delay_ready = v[15:0];
      REG_DELAY_ACTIVE: flt_cfg.delay_active = v[15:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got_v, longint want_v);
    fail_count++;
    $display("result %0d %s: got %0d expected %0d", results_seen, field, got_v, want_v);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(sample_t s, bit known, result_t want);
    result_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    predicted = predict_filter(s);
    expected_results.push_back(known ? want : predicted);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic add_row(bit wr_en, logic [2:0] wr_reg, logic [31:0] wr_val,
                         logic [23:0] raw, logic [19:0] el, bit known, result_t want);
    script_row_t row;
    row.wr_en = wr_en;
    row.wr_reg = wr_reg;
    row.wr_val = wr_val;
    row.smp.raw_speed = raw;
    row.smp.elapsed = el;
    row.known = known;
    row.want = want;
    script.push_back(row);
  endtask

  task automatic setup_phase(int p);
    logic [15:0] gear, dly_rdy, dly_act;
    logic [23:0] recip, target;
    logic [22:0] thr_e, thr_d;
    logic [7:0]  cc;
    gear = p == 2 ? 16'hFFFF : p == 5 ? 16'h0000 : 16'($urandom_range(128, 1024));
    recip = p == 2 ? 24'hFFFFFF : p == 5 ? 24'h0 : 24'($urandom_range(1 << 16, 1 << 21));
    target = p == 2 ? 24'h7FFFFF : p == 5 ? 24'h800000 :
             24'($urandom_range(0, 1 << 19) - (1 << 18));
    thr_e = p == 2 ? 23'h7FFFFF : p == 5 ? 23'h0 : 23'($urandom_range(256, 8192));
    thr_d = p == 2 ? 23'h7FFFFF : p == 5 ? 23'h0 : 23'($urandom_range(1 << 10, 1 << 18));
    cc = p == 2 ? 8'd255 : p == 5 ? 8'd1 : p == 6 ? 8'd0 : 8'($urandom_range(1, 16));
    dly_rdy = p == 2 ? 16'hFFFF : p == 5 ? 16'h0 : 16'($urandom);
    dly_act = p == 2 ? 16'h0 : p == 5 ? 16'hFFFF : 16'($urandom);
    write_reg(REG_GEARING, {16'h0, gear});
    write_reg(REG_RECIP, {8'h0, recip});
    write_reg(REG_TARGET, {8'h0, target});
    write_reg(REG_THR_ERR, {9'h0, thr_e});
    write_reg(REG_THR_DER, {9'h0, thr_d});
    write_reg(REG_CHECK_CYCLE, {24'h0, cc});
    write_reg(REG_DELAY_READY, {16'h0, dly_rdy});
    write_reg(REG_DELAY_ACTIVE, {16'h0, dly_act});
  endtask

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.filtered_speed !== want.filtered_speed)
          report_mismatch("filtered_speed", longint'($signed(result.filtered_speed)),
                          longint'($signed(want.filtered_speed)));
        if (result.filtered_slope !== want.filtered_slope)
          report_mismatch("filtered_slope", longint'($signed(result.filtered_slope)),
                          longint'($signed(want.filtered_slope)));
        if (result.speed_error !== want.speed_error)
          report_mismatch("speed_error", longint'($signed(result.speed_error)),
                          longint'($signed(want.speed_error)));
        if (result.is_ready !== want.is_ready)
          report_mismatch("is_ready", result.is_ready, want.is_ready);
        if (result.became_ready !== want.became_ready)
          report_mismatch("became_ready", result.became_ready, want.became_ready);
        if (result.became_active !== want.became_active)
          report_mismatch("became_active", result.became_active, want.became_active);
        if (result.frame_delay !== want.frame_delay)
          report_mismatch("frame_delay", result.frame_delay, want.frame_delay);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("speed_filter_settle_detect verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         p, sent, len;
    longint     lvl, lim;
    sample_t    s;
    flt_cfg = '{GEARING_RST, RECIP_RST, 24'sd0, 23'd0, 23'd0, CHECK_CYCLE_RST,
                DELAY_READY_RST, DELAY_ACTIVE_RST};
    est_speed = '0;
    est_slope = '0;
    settled_flag = 1'b1;
    samples_seen = '0;

    add_row(0, REG_GEARING, 0, 24'h000000, 20'h00000, 1,
            '{24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 16'd20});
    add_row(0, REG_GEARING, 0, 24'h7FFFFF, 20'h00000, 1,
            '{24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 16'd20});
    add_row(0, REG_GEARING, 0, 24'h800000, 20'h00000, 1,
            '{24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0, 16'd20});
    add_row(0, REG_GEARING, 0, 24'h7FFFFF, 20'hFFFFF, 1,
            '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, 1'b0, 16'd20});
    add_row(0, REG_GEARING, 0, 24'h800000, 20'hFFFFF, 1,
            '{24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0, 1'b0, 16'd20});
    add_row(0, REG_GEARING, 0, 24'h000100, 20'h02000, 0, '0);
    add_row(0, REG_GEARING, 0, 24'h123456, 20'h04000, 0, '0);
    add_row(0, REG_GEARING, 0, 24'hFF6000, 20'h08000, 0, '0);
    add_row(0, REG_GEARING, 0, 24'h000000, 20'h00001, 0, '0);
    // tenth sample: first check, ready drops against zero thresholds
    add_row(0, REG_GEARING, 0, 24'h3FFF00, 20'h10000, 0, '0);
    add_row(1, REG_DELAY_READY, 32'h0000FFFF, 24'h000000, 20'h00000, 0, '0);
    add_row(1, REG_DELAY_ACTIVE, 32'h0, 24'h000000, 20'h00000, 0, '0);
    add_row(1, REG_THR_ERR, 32'h007FFFFF, 24'hABCDEF, 20'h55555, 0, '0);
    add_row(1, REG_THR_DER, 32'h007FFFFF, 24'h543210, 20'hAAAAA, 0, '0);
    add_row(1, REG_CHECK_CYCLE, 32'h0, 24'h800000, 20'hFFFFF, 0, '0);
    // most negative error never counts as settled
    add_row(1, REG_TARGET, 32'h007FFFFF, 24'h800000, 20'hFFFFF, 0, '0);
    add_row(1, REG_TARGET, 32'h00800000, 24'h000000, 20'h00000, 0, '0);
    add_row(1, REG_GEARING, 32'h0000FFFF, 24'h7FFFFF, 20'h00400, 0, '0);
    add_row(1, REG_GEARING, 32'h0, 24'h400000, 20'h00400, 0, '0);
    add_row(1, REG_RECIP, 32'h00FFFFFF, 24'h001000, 20'h00100, 0, '0);
    add_row(1, REG_RECIP, 32'h0, 24'hC00000, 20'hFFFFF, 0, '0);
    add_row(1, REG_CHECK_CYCLE, 32'h000000FF, 24'h000001, 20'h00010, 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].wr_en) begin
        drain();
        write_reg(script[i].wr_reg, script[i].wr_val);
      end
      push_sample(script[i].smp, script[i].known, script[i].want);
    end

    for (p = 0; p < 8; p++) begin
      drain();
      setup_phase(p);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct = 30;
          stall_pct = 30;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          // settle run: hold a level near the geared target, at times offset further from it
          len = $urandom_range(4, 30);
          if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
          if (flt_cfg.gearing == 16'd0) begin
            lvl = longint'($signed(24'($urandom)));
          end else begin
            lvl = longint'($signed(flt_cfg.target_speed)) * 256 / longint'(flt_cfg.gearing);
          end
          if ($urandom_range(9) < 3) begin
            lvl = lvl + longint'($urandom_range(0, 1 << 16)) - 32768;
          end else begin
            lvl = lvl + longint'($urandom_range(0, 64)) - 32;
          end
          if (flt_cfg.smoothing_recip == 24'd0) begin
            lim = 64'hFFFFF;
          end else begin
            lim = (longint'(1) <<< 35) / longint'(flt_cfg.smoothing_recip);
          end
          if (lim > 64'hFFFFF) lim = 64'hFFFFF;
          if (lim < 8) lim = 8;
          repeat (len) begin
            s.raw_speed = clamp24(lvl + longint'($urandom_range(0, 16)) - 8);
            s.elapsed = 20'($urandom_range(32'(lim / 4), 32'(lim)));
            push_sample(s, 1'b0, '0);
            sent++;
          end
        end else begin
          len = $urandom_range(1, 4);
          if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
          repeat (len) begin
            s.raw_speed = 24'($urandom);
            s.elapsed = $urandom_range(3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 1 << 14));
            push_sample(s, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("speed_filter_settle_detect verification clean");
    end else begin
      $display("speed_filter_settle_detect verification failed");
    end
    $finish;
  end

endmodule

// ===== speed_filter_settle_detect.f =====
rtl/sfsd_pkg.sv
rtl/sfsd_regs.sv
rtl/sfsd_seq.sv
rtl/sfsd_datapath.sv
rtl/speed_filter_settle_detect.sv
rtl/sfsd_checker.sv
test/tb_speed_filter_settle_detect.sv
